### sv/joystick_eight_sector_quantizer_assert.svh
// Assertion macros for the checker file of the quantizer.
`ifndef JOYSTICK_EIGHT_SECTOR_QUANTIZER_ASSERT_SVH
`define JOYSTICK_EIGHT_SECTOR_QUANTIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define JESQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define JESQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/jesq_pkg.sv
// Shared types and constants of the joystick eight-sector quantizer.
package jesq_pkg;

  // Direction codes, compass style: north is forward, east is right
  localparam logic [3:0] HEAD_IDLE = 4'd0;
  localparam logic [3:0] HEAD_N    = 4'd1;
  localparam logic [3:0] HEAD_S    = 4'd2;
  localparam logic [3:0] HEAD_W    = 4'd3;
  localparam logic [3:0] HEAD_E    = 4'd4;
  localparam logic [3:0] HEAD_NW   = 4'd5;
  localparam logic [3:0] HEAD_NE   = 4'd6;
  localparam logic [3:0] HEAD_SW   = 4'd7;
  localparam logic [3:0] HEAD_SE   = 4'd8;

  // tan(22.5 deg) in unsigned Q0.16
  localparam logic [23:0] TAN_Q16 = 24'd27146;

  localparam logic [6:0]  MAG_MAX        = 7'd100;
  localparam logic [15:0] MAG_SAT_SQ     = 16'd10000;
  localparam logic [6:0]  DEADZONE_RESET = 7'd20;
  localparam logic [13:0] DZ_SQ_RESET    = 14'(20 * 20);

  localparam logic [1:0] REG_DEADZONE = 2'd0;

  // Output of the front end (after the squares and the sector compares)
  typedef struct packed {
    logic [14:0] xx;
    logic [14:0] yy;
    logic        x_neg;
    logic        y_neg;
    logic        is_zero;
    logic        horiz;   // |y| < |x| * tan
    logic        vert;    // |x| < |y| * tan
  } front_t;

  // Output of the classifier, input of the root pipeline
  typedef struct packed {
    logic [13:0] s_lo;
    logic        sat;
    logic [3:0]  dir;
  } cls_t;

  // Try one result bit of the integer square root
  function automatic logic [6:0] sqrt_step(input logic [6:0] r, input logic [13:0] s,
                                           input logic [2:0] bitpos);
    logic [6:0]  t;
    logic [13:0] sq;
    t  = r | (7'd1 << bitpos);
    sq = {7'b0, t} * {7'b0, t};
    return (sq <= s) ? t : r;
  endfunction

endpackage

### sv/joystick_eight_sector_quantizer.sv
// Top level of the joystick eight-sector quantizer.
//
// Each sample beat (x_pos, y_pos, signed 8-bit) yields one result beat:
// magnitude = min(floor(sqrt(x^2 + y^2)), 100) and a direction code
// (0 stop, 1 forward, 2 back, 3 left, 4 right, 5 forward-left,
// 6 forward-right, 7 back-left, 8 back-right). Stop is reported when
// x^2 + y^2 is below deadzone^2; the magnitude is reported either way. The
// sector comes from exact compares against tan(22.5 deg) in Q0.16, no
// arctangent. The block takes one sample per cycle while no result is held
// back; an accepted sample reaches its result through one stage for absolute
// values, one for the squares and sector compares, one for the sum and
// classification, and four for the square root, two result bits per stage
// but one in the last. The last root stage is the output register. A
// one-deep skid register at the input keeps sample_ready a plain flop; while
// a result waits with result_ready low, the pipeline freezes, one more sample
// beat is caught in the skid and sample_ready then falls until the output
// side moves again. The deadzone register (byte address 0, reset 20) is
// written and read over the APB port with zero wait states; write it only
// while no samples are in flight.
module joystick_eight_sector_quantizer (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [7:0]  x_pos,
  input  logic [7:0]  y_pos,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [3:0]  direction,
  output logic [6:0]  magnitude,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jesq_pkg::*;

  logic        en;
  logic        skid_valid;
  logic [7:0]  skid_x;
  logic [7:0]  skid_y;
  logic        feed_valid;
  logic [7:0]  feed_x;
  logic [7:0]  feed_y;

  logic [6:0]  deadzone;
  logic [13:0] dz_sq;
  logic        cfg_wr;

  logic        front_valid;
  front_t      front;
  logic        cls_valid;
  cls_t        cls;

  // Advance the whole pipeline unless a finished result is held back.
  assign en = !result_valid || result_ready;

  // Skid register: catch a beat accepted while the pipeline is frozen.
  assign sample_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (sample_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && sample_valid && !skid_valid) begin
      skid_x <= x_pos;
      skid_y <= y_pos;
    end
  end

  // Drain the skid first; otherwise pass the live beat straight in.
  assign feed_valid = skid_valid || sample_valid;
  assign feed_x     = skid_valid ? skid_x : x_pos;
  assign feed_y     = skid_valid ? skid_y : y_pos;

  // Configuration: deadzone and its square, kept together.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_DEADZONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= DEADZONE_RESET;
      dz_sq    <= DZ_SQ_RESET;
    end else if (cfg_wr) begin
      deadzone <= pwdata[6:0];
      dz_sq    <= {7'b0, pwdata[6:0]} * {7'b0, pwdata[6:0]};
    end
  end

  assign prdata = (paddr == REG_DEADZONE) ? {25'b0, deadzone} : 32'b0;

  jesq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .feed_valid  (feed_valid),
    .feed_x      (feed_x),
    .feed_y      (feed_y),
    .front_valid (front_valid),
    .front       (front)
  );

  jesq_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .dz_sq       (dz_sq),
    .front_valid (front_valid),
    .front       (front),
    .cls_valid   (cls_valid),
    .cls         (cls)
  );

  jesq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cls_valid (cls_valid),
    .cls       (cls),
    .out_valid (result_valid),
    .out_dir   (direction),
    .out_mag   (magnitude)
  );

endmodule

### sv/jesq_front.sv
// Front end: absolute values, then squares and sector compares.
module jesq_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  feed_valid,
  input  logic [7:0]            feed_x,
  input  logic [7:0]            feed_y,
  output logic                  front_valid,
  output jesq_pkg::front_t      front
);
  import jesq_pkg::*;

  logic       v1;
  logic [7:0] ax;
  logic [7:0] ay;
  logic       xn;
  logic       yn;

  front_t     front_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= feed_valid;
    end
  end

  // -128 folds to 8'h80, read as unsigned 128
  always_ff @(posedge clk) begin
    if (en) begin
      ax <= feed_x[7] ? (~feed_x + 8'd1) : feed_x;
      ay <= feed_y[7] ? (~feed_y + 8'd1) : feed_y;
      xn <= feed_x[7];
      yn <= feed_y[7];
    end
  end

  always_comb begin
    front_next.xx      = {7'b0, ax} * {7'b0, ax};
    front_next.yy      = {7'b0, ay} * {7'b0, ay};
    front_next.x_neg   = xn;
    front_next.y_neg   = yn;
    front_next.is_zero = (ax == 8'd0) && (ay == 8'd0);
    front_next.horiz   = {ay, 16'b0} < ({16'b0, ax} * TAN_Q16);
    front_next.vert    = {ax, 16'b0} < ({16'b0, ay} * TAN_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (en) begin
      front_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule

### sv/jesq_classify.sv
// Classifier: sum of squares, deadzone test and sector code.
module jesq_classify (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [13:0]           dz_sq,
  input  logic                  front_valid,
  input  jesq_pkg::front_t      front,
  output logic                  cls_valid,
  output jesq_pkg::cls_t        cls
);
  import jesq_pkg::*;

  logic [15:0] s;
  cls_t        cls_next;

  always_comb begin
    s = {1'b0, front.xx} + {1'b0, front.yy};
    cls_next.s_lo = s[13:0];
    cls_next.sat  = (s >= MAG_SAT_SQ);
    if (s < {2'b0, dz_sq}) begin
      cls_next.dir = HEAD_IDLE;
    end else if (front.is_zero) begin
      cls_next.dir = HEAD_E;
    end else if (front.horiz) begin
      cls_next.dir = front.x_neg ? HEAD_W : HEAD_E;
    end else if (front.vert) begin
      cls_next.dir = front.y_neg ? HEAD_S : HEAD_N;
    end else if (!front.y_neg) begin
      cls_next.dir = front.x_neg ? HEAD_NW : HEAD_NE;
    end else begin
      cls_next.dir = front.x_neg ? HEAD_SW : HEAD_SE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (en) begin
      cls_valid <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls <= cls_next;
    end
  end

endmodule

### sv/jesq_sqrt.sv
// Root pipeline: two root bits per stage (one in the last), then saturation.
module jesq_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  cls_valid,
  input  jesq_pkg::cls_t        cls,
  output logic                  out_valid,
  output logic [3:0]            out_dir,
  output logic [6:0]            out_mag
);
  import jesq_pkg::*;

  localparam int Stages = 4;

  logic [Stages:0] v;
  cls_t            c   [Stages+1];
  logic [6:0]      r   [Stages+1];
  logic [6:0]      mag_final;

  assign v[0] = cls_valid;
  assign c[0] = cls;
  assign r[0] = 7'd0;

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [6:0] r_next;

    always_comb begin
      r_next = sqrt_step(r[k], c[k].s_lo, 3'(6 - 2 * k));
      if (k < Stages - 1) begin
        r_next = sqrt_step(r_next, c[k].s_lo, 3'(5 - 2 * k));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c[k+1] <= c[k];
        r[k+1] <= r_next;
      end
    end
  end

  assign mag_final = c[Stages].sat ? MAG_MAX : r[Stages];

  assign out_valid = v[Stages];
  assign out_dir   = c[Stages].dir;
  assign out_mag   = mag_final;

endmodule

### sv/jesq_checker.sv
// Port-level checker of the quantizer and its bind.
`include "joystick_eight_sector_quantizer_assert.svh"

module jesq_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [3:0]  direction,
  input logic [6:0]  magnitude,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import jesq_pkg::*;

  // A stalled result beat holds.
  `JESQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(direction) && $stable(magnitude), "result beat changed while stalled")

  // Results stay within their code and value ranges.
  `JESQ_ASSERT_NOW(a_result_range, result_valid, direction <= HEAD_SE && magnitude <= MAG_MAX, "result out of range")

  // The input skid drains as soon as the output side moves.
  `JESQ_ASSERT_NEXT(a_skid_drain, !sample_ready && result_ready, sample_ready, "skid did not drain")

  // A deadzone write reads back on the next cycle.
  `JESQ_ASSERT_NOW(a_cfg_readback, $past(psel && penable && pwrite && paddr == REG_DEADZONE && !rst) && paddr == REG_DEADZONE, prdata[6:0] == $past(pwdata[6:0]) && prdata[31:7] == 25'b0, "deadzone readback mismatch")

endmodule

bind joystick_eight_sector_quantizer jesq_checker u_jesq_checker (.*);
